>>> rtl/sds_pkg.sv
// Package with types, constants and saturation helpers for the steepest descent solver.
package sds_pkg;

  localparam int N_MAX     = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(N_MAX);
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    REQ_MATRIX = 2'd0,
    REQ_RHS    = 2'd1,
    REQ_START  = 2'd2,
    REQ_SOLVE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DEN  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SIZE      = 2'd0,
    CFG_MAX_ITER  = 2'd1,
    CFG_TOLERANCE = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MVX, S_RES, S_NORM, S_CHECK, S_MVR, S_DEN,
    S_DIVGO, S_DIVWAIT, S_UPD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_RD, PH_MUL, PH_ACC
  } phase_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [3:0]         element_index;
    logic signed [31:0] solution_value;
    logic [15:0]        iterations_done;
    logic [31:0]        final_norm;
    logic [1:0]         status;
    logic               last;
  } out_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] U32_MAX = 64'sd4294967295;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] satu32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v < 64'sd0) begin
      r = 32'd0;
    end else if (v > U32_MAX) begin
      r = 32'hffffffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/sds_mac.sv
// Shared multiplier with registered floor-shifted product.
module sds_mac (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  logic signed [63:0] full;

  assign full = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    prod_r <= full >>> sds_pkg::FRAC_BITS;
  end

endmodule

>>> rtl/sds_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module sds_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sds_pkg::DIV_W-1:0]     dividend,
  input  logic [31:0]                   divisor,
  output logic [sds_pkg::DIV_W-1:0]     quo_r,
  output logic                          done_r
);

  logic [31:0]                  rem_r;
  logic [31:0]                  dsr_r;
  logic [sds_pkg::DIV_CW-1:0]   cnt_r;
  logic                         busy_r;
  logic [32:0]                  shifted;
  logic                         take;

  assign shifted = {rem_r, quo_r[sds_pkg::DIV_W-1]};
  assign take    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == sds_pkg::DIV_CW'(sds_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? 32'(shifted - {1'b0, dsr_r}) : shifted[31:0];
      quo_r <= {quo_r[sds_pkg::DIV_W-2:0], take};
    end
  end

endmodule

>>> rtl/steepest_descent_solver_top.sv
// Top level of the steepest descent solver: stores, sequencer and result register.
// The block accepts load words back to back while idle.
// A solve word runs one shared multiplier under a sequencer, with read, multiply and
// accumulate phases per product: a start pass, then update passes (each with two
// matrix-vector products, the vector passes and a 48-bit bit-serial divider); the
// final pass leaves out the residual refresh and its check. The n result words
// follow one at a time as the consumer takes them. The block takes no input word
// after a solve until its last result is loaded into the output register.
module steepest_descent_solver_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sds_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int IW = sds_pkg::IDX_W;

  sds_pkg::state_t state_r, state_nxt;
  sds_pkg::phase_t ph_r;

  logic [4:0]  size_r;
  logic [15:0] max_r;
  logic [31:0] tol_r;

  logic [IW-1:0] i_r, j_r, nm1_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic [31:0] norm_r;
  logic signed [31:0] den_r, den_nxt, alpha_r;
  logic [15:0] iters_r;
  logic [1:0]  status_r;

  logic signed [31:0] mat_mem [0:(1<<sds_pkg::MAT_AW)-1];
  logic signed [31:0] b_mem [0:(1<<IW)-1];
  logic signed [31:0] x_mem [0:(1<<IW)-1];
  logic signed [31:0] r_mem [0:(1<<IW)-1];
  logic signed [31:0] p_mem [0:(1<<IW)-1];
  logic signed [31:0] mat_rd_r, b_rd_r, x_rd_r, r_rd_r, p_rd_r;

  logic mat_we, b_we, x_we, r_we, p_we;
  logic [sds_pkg::MAT_AW-1:0] mat_wa;
  logic [IW-1:0] b_wa, x_wa;
  logic signed [31:0] x_wd, r_wd, p_wd;

  logic signed [31:0] mac_a, mac_b;
  logic signed [63:0] prod_r;
  logic div_start, div_done;
  logic [sds_pkg::DIV_W-1:0] quo;
  logic [31:0] den_mag;

  logic in_acc, load_ok, row_ok, can_load, step, last_j, last_i;
  logic signed [31:0] upd_t;
  logic out_valid_r;
  sds_pkg::out_t out_r;

  assign in_acc   = in_valid && in_ready;
  assign row_ok   = 32'(in_data.row_index) < sds_pkg::N_MAX;
  assign load_ok  = in_acc && row_ok && (in_data.req_type != sds_pkg::REQ_SOLVE) &&
                    ((in_data.req_type != sds_pkg::REQ_MATRIX) ||
                     (32'(in_data.col_index) < sds_pkg::N_MAX));
  assign can_load = !out_valid_r || out_ready;
  assign last_j   = j_r == nm1_r;
  assign last_i   = i_r == nm1_r;
  assign step     = (ph_r == sds_pkg::PH_ACC) && ((state_r != sds_pkg::S_EMIT) || can_load);
  assign acc_nxt  = acc_r + prod_r;
  assign den_nxt  = sds_pkg::sat32(acc_nxt);
  assign upd_t    = sds_pkg::sat32(prod_r);
  assign den_mag  = den_r[31] ? 32'(-{1'b1, den_r}) : den_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sds_mac u_mac (
    .clk    (clk),
    .a      (mac_a),
    .b      (mac_b),
    .prod_r (prod_r)
  );

  sds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({norm_r, {sds_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (den_mag),
    .quo_r    (quo),
    .done_r   (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sds_pkg::S_IDLE: begin
        if (in_acc && in_data.req_type == sds_pkg::REQ_SOLVE) state_nxt = sds_pkg::S_START;
      end
      sds_pkg::S_START: state_nxt = sds_pkg::S_MVX;
      sds_pkg::S_MVX: begin
        if (step && last_j && last_i) state_nxt = sds_pkg::S_RES;
      end
      sds_pkg::S_RES: begin
        if (step && last_j) state_nxt = sds_pkg::S_NORM;
      end
      sds_pkg::S_NORM: begin
        if (step && last_j) state_nxt = sds_pkg::S_CHECK;
      end
      sds_pkg::S_CHECK: begin
        if (iters_r == max_r || norm_r < tol_r) state_nxt = sds_pkg::S_EMIT;
        else state_nxt = sds_pkg::S_MVR;
      end
      sds_pkg::S_MVR: begin
        if (step && last_j && last_i) state_nxt = sds_pkg::S_DEN;
      end
      sds_pkg::S_DEN: begin
        if (step && last_j) begin
          state_nxt = (den_nxt == 32'sd0) ? sds_pkg::S_EMIT : sds_pkg::S_DIVGO;
        end
      end
      sds_pkg::S_DIVGO: state_nxt = sds_pkg::S_DIVWAIT;
      sds_pkg::S_DIVWAIT: begin
        if (div_done) state_nxt = sds_pkg::S_UPD;
      end
      sds_pkg::S_UPD: begin
        if (step && last_j) begin
          state_nxt = (17'(iters_r) + 17'd1 == 17'(max_r)) ? sds_pkg::S_EMIT : sds_pkg::S_MVX;
        end
      end
      sds_pkg::S_EMIT: begin
        if (step && last_j) state_nxt = sds_pkg::S_IDLE;
      end
      default: state_nxt = sds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == sds_pkg::S_IDLE;
    div_start = state_r == sds_pkg::S_DIVGO;
    mat_we = load_ok && in_data.req_type == sds_pkg::REQ_MATRIX;
    b_we   = load_ok && in_data.req_type == sds_pkg::REQ_RHS;
    mat_wa = {IW'(in_data.row_index), IW'(in_data.col_index)};
    b_wa   = IW'(in_data.row_index);
    x_we   = 1'b0;
    x_wa   = j_r;
    x_wd   = upd_t;
    r_we   = 1'b0;
    r_wd   = upd_t;
    p_we   = 1'b0;
    p_wd   = den_nxt;
    mac_a  = mat_rd_r;
    mac_b  = x_rd_r;
    if (load_ok && in_data.req_type == sds_pkg::REQ_START) begin
      x_we = 1'b1;
      x_wa = IW'(in_data.row_index);
      x_wd = in_data.value;
    end
    unique case (state_r)
      sds_pkg::S_MVX: p_we = step && last_j;
      sds_pkg::S_MVR: begin
        mac_b = r_rd_r;
        p_we  = step && last_j;
      end
      sds_pkg::S_RES: begin
        r_we = step;
        r_wd = sds_pkg::sat32(64'(b_rd_r) - 64'(p_rd_r));
      end
      sds_pkg::S_NORM: begin
        mac_a = r_rd_r;
        mac_b = r_rd_r;
      end
      sds_pkg::S_DEN: begin
        mac_a = p_rd_r;
        mac_b = r_rd_r;
      end
      sds_pkg::S_UPD: begin
        mac_a = alpha_r;
        mac_b = r_rd_r;
        r_we  = step;
        x_we  = step;
        x_wd  = sds_pkg::sat32(64'(x_rd_r) + 64'(upd_t));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= in_data.value;
    mat_rd_r <= mat_mem[{i_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= in_data.value;
    b_rd_r <= b_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    x_rd_r <= x_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (r_we) r_mem[j_r] <= r_wd;
    r_rd_r <= r_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[i_r] <= p_wd;
    p_rd_r <= p_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sds_pkg::S_IDLE;
      ph_r        <= sds_pkg::PH_RD;
      size_r      <= 5'd16;
      max_r       <= 16'd100;
      tol_r       <= 32'd1;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      nm1_r       <= '0;
      iters_r     <= '0;
      status_r    <= sds_pkg::ST_LIMIT;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sds_pkg::CFG_SIZE:      size_r <= cfg_data[4:0];
          sds_pkg::CFG_MAX_ITER:  max_r  <= cfg_data[15:0];
          sds_pkg::CFG_TOLERANCE: tol_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == sds_pkg::S_EMIT && step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_nxt != state_r) begin
        ph_r <= sds_pkg::PH_RD;
        j_r  <= '0;
        i_r  <= '0;
      end else if (ph_r == sds_pkg::PH_RD) begin
        ph_r <= sds_pkg::PH_MUL;
      end else if (ph_r == sds_pkg::PH_MUL) begin
        ph_r <= sds_pkg::PH_ACC;
      end else if (step) begin
        ph_r <= sds_pkg::PH_RD;
        if (last_j) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      unique case (state_r)
        sds_pkg::S_START: begin
          iters_r <= '0;
          if (size_r == 5'd0) nm1_r <= '0;
          else if (32'(size_r) > sds_pkg::N_MAX) nm1_r <= IW'(sds_pkg::N_MAX - 1);
          else nm1_r <= IW'(size_r - 5'd1);
        end
        sds_pkg::S_CHECK: begin
          if (iters_r == max_r) begin
            status_r <= (max_r == 16'd0 && norm_r < tol_r) ? sds_pkg::ST_CONVERGED
                                                             : sds_pkg::ST_LIMIT;
          end else if (norm_r < tol_r) begin
            status_r <= sds_pkg::ST_CONVERGED;
          end
        end
        sds_pkg::S_DEN: begin
          if (step && last_j && den_nxt == 32'sd0) status_r <= sds_pkg::ST_ZERO_DEN;
        end
        sds_pkg::S_UPD: begin
          if (step && last_j) begin
            iters_r  <= iters_r + 16'd1;
            status_r <= sds_pkg::ST_LIMIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sds_pkg::S_START) begin
      acc_r <= '0;
    end else if (step && (state_r == sds_pkg::S_MVX || state_r == sds_pkg::S_MVR ||
                          state_r == sds_pkg::S_NORM || state_r == sds_pkg::S_DEN)) begin
      acc_r <= last_j ? 64'sd0 : acc_nxt;
    end
    if (state_r == sds_pkg::S_NORM && step && last_j) norm_r <= sds_pkg::satu32(acc_nxt);
    if (state_r == sds_pkg::S_DEN && step && last_j) den_r <= den_nxt;
    if (div_done) begin
      if (!den_r[31]) begin
        alpha_r <= (quo > sds_pkg::DIV_W'(32'h7fffffff)) ? 32'sh7fffffff : quo[31:0];
      end else begin
        alpha_r <= (quo > sds_pkg::DIV_W'(32'h80000000)) ? 32'sh80000000 : -quo[31:0];
      end
    end
    if (state_r == sds_pkg::S_EMIT && step) begin
      out_r.element_index   <= 4'(j_r);
      out_r.solution_value  <= x_rd_r;
      out_r.iterations_done <= iters_r;
      out_r.final_norm      <= norm_r;
      out_r.status          <= status_r;
      out_r.last            <= last_j;
    end
  end

endmodule

>>> dv/steepest_descent_solver_top_tb.sv
// Self-checking testbench for the steepest descent solver: directed, pressure and random solve runs.
`timescale 1ns / 1ps

module steepest_descent_solver_top_tb;

  localparam int STALL_LIMIT = 40000;
  localparam int LONG_HOLD   = 3000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  sds_pkg::in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  sds_pkg::out_t  out_data;
  logic  cfg_valid;
  logic  cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  steepest_descent_solver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  int mat_m [16][16];
  int rhs_m [16];
  int sol_m [16];
  int res_m [16];
  int prod_m [16];
  int unsigned size_reg;
  int unsigned iter_reg;
  int unsigned tol_reg;

  sds_pkg::out_t solution_words [$];
  bit   failed;
  bit   send_burst;
  bit   recv_burst;
  bit   hold_req;
  int   idle_cycles;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint fxmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> sds_pkg::FRAC_BITS;
  endfunction

  function automatic longint dot_sum(int u[16], int v[16], int n);
    longint s;
    s = 0;
    for (int i = 0; i < n; i++) s += fxmul(u[i], v[i]);
    return s;
  endfunction

  function automatic void mat_times(int v[16], int n);
    for (int i = 0; i < n; i++) prod_m[i] = clip32(dot_sum(mat_m[i], v, n));
  endfunction

  function automatic void residual_update(int n);
    mat_times(sol_m, n);
    for (int i = 0; i < n; i++) res_m[i] = clip32(longint'(rhs_m[i]) - longint'(prod_m[i]));
  endfunction

  function automatic int unsigned residual_norm(int n);
    longint s;
    s = dot_sum(res_m, res_m, n);
    if (s < 0) return 0;
    if (s > 64'sd4294967295) return 32'hffffffff;
    return s[31:0];
  endfunction

  function automatic void predict_solve();
    int n;
    int unsigned iters;
    int unsigned nrm;
    int den;
    int alpha;
    sds_pkg::status_t st;
    sds_pkg::out_t w;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > sds_pkg::N_MAX) n = sds_pkg::N_MAX;
    iters = 0;
    st = sds_pkg::ST_LIMIT;
    residual_update(n);
    nrm = residual_norm(n);
    if (iter_reg == 0 && nrm < tol_reg) st = sds_pkg::ST_CONVERGED;
    while (iters < iter_reg) begin
      nrm = residual_norm(n);
      if (nrm < tol_reg) begin
        st = sds_pkg::ST_CONVERGED;
        break;
      end
      mat_times(res_m, n);
      den = clip32(dot_sum(prod_m, res_m, n));
      if (den == 0) begin
        st = sds_pkg::ST_ZERO_DEN;
        break;
      end
      alpha = clip32((longint'(nrm) <<< sds_pkg::FRAC_BITS) / longint'(den));
      for (int i = 0; i < n; i++) begin
        res_m[i] = clip32(fxmul(alpha, res_m[i]));
        sol_m[i] = clip32(longint'(sol_m[i]) + longint'(res_m[i]));
      end
      residual_update(n);
      iters++;
    end
    for (int i = 0; i < n; i++) begin
      w.element_index   = i[3:0];
      w.solution_value  = sol_m[i];
      w.iterations_done = iters[15:0];
      w.final_norm      = nrm;
      w.status          = st;
      w.last            = (i == n - 1);
      solution_words.push_back(w);
    end
  endfunction

  function automatic void predict_word(sds_pkg::in_t it);
    case (sds_pkg::req_t'(it.req_type))
      sds_pkg::REQ_MATRIX: mat_m[it.row_index][it.col_index] = it.value;
      sds_pkg::REQ_RHS:    rhs_m[it.row_index] = it.value;
      sds_pkg::REQ_START:  sol_m[it.row_index] = it.value;
      default:             predict_solve();
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sds_pkg::out_t exp_w;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
        if (hold_req && !(out_valid && out_ready)) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_req = 0;
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end while (!(out_valid && out_ready));
      if (solution_words.size() == 0) begin
        $error("unexpected result word, element_index %0d", out_data.element_index);
        failed = 1;
      end else begin
        exp_w = solution_words.pop_front();
        if (out_data.element_index !== exp_w.element_index) begin
          $error("element_index exp %0d act %0d", exp_w.element_index, out_data.element_index);
          failed = 1;
        end
        if (out_data.solution_value !== exp_w.solution_value) begin
          $error("solution_value exp %0d act %0d", exp_w.solution_value,
                 out_data.solution_value);
          failed = 1;
        end
        if (out_data.iterations_done !== exp_w.iterations_done) begin
          $error("iterations_done exp %0d act %0d", exp_w.iterations_done,
                 out_data.iterations_done);
          failed = 1;
        end
        if (out_data.final_norm !== exp_w.final_norm) begin
          $error("final_norm exp %0d act %0d", exp_w.final_norm, out_data.final_norm);
          failed = 1;
        end
        if (out_data.status !== exp_w.status) begin
          $error("status exp %0d act %0d", exp_w.status, out_data.status);
          failed = 1;
        end
        if (out_data.last !== exp_w.last) begin
          $error("last exp %0d act %0d", exp_w.last, out_data.last);
          failed = 1;
        end
      end
    end
  end

  task automatic send_word(sds_pkg::req_t kind, int row, int col, int val);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, row_index: row[3:0], col_index: col[3:0], value: val};
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_word(in_data);
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(sds_pkg::cfg_idx_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      sds_pkg::CFG_SIZE:      size_reg = val & 32'h1f;
      sds_pkg::CFG_MAX_ITER:  iter_reg = val & 32'hffff;
      sds_pkg::CFG_TOLERANCE: tol_reg  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_solver(int unsigned sz, int unsigned iters, int unsigned tol);
    write_reg(sds_pkg::CFG_SIZE, sz);
    write_reg(sds_pkg::CFG_MAX_ITER, iters);
    write_reg(sds_pkg::CFG_TOLERANCE, tol);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (solution_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'sh7fffffff;
      2:       return 32'sh80000000;
      3:       return 0;
      default: return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  task automatic test_fill_stores();
    for (int r = 0; r < 16; r++) begin
      for (int c = 0; c < 16; c++) send_word(sds_pkg::REQ_MATRIX, r, c, rand_value());
      send_word(sds_pkg::REQ_RHS, r, 0, rand_value());
      send_word(sds_pkg::REQ_START, r, $urandom_range(0, 15), rand_value());
    end
    wait_drained();
  endtask

  task automatic test_special_cases();
    write_reg(sds_pkg::CFG_NONE, 32'hffffffff);
    set_solver(1, 65535, 0);
    send_word(sds_pkg::REQ_MATRIX, 0, 0, 0);
    send_word(sds_pkg::REQ_RHS, 0, 0, 32'sh10000);
    send_word(sds_pkg::REQ_START, 0, 0, 0);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
    set_solver(1, 65535, 32'hffffffff);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
    set_solver(2, 0, 1);
    send_word(sds_pkg::REQ_MATRIX, 0, 0, 32'sh7fffffff);
    send_word(sds_pkg::REQ_MATRIX, 1, 1, 32'sh80000000);
    send_word(sds_pkg::REQ_MATRIX, 0, 1, 32'sh10000);
    send_word(sds_pkg::REQ_MATRIX, 1, 0, 32'sh10000);
    send_word(sds_pkg::REQ_RHS, 1, 15, 32'sh80000000);
    send_word(sds_pkg::REQ_SOLVE, 15, 15, 32'hffffffff);
    wait_drained();
    set_solver(2, 3, 0);
    send_word(sds_pkg::REQ_MATRIX, 0, 0, 32'sh20000);
    send_word(sds_pkg::REQ_MATRIX, 1, 1, 32'sh30000);
    send_word(sds_pkg::REQ_MATRIX, 0, 1, 0);
    send_word(sds_pkg::REQ_MATRIX, 1, 0, 0);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
    set_solver(0, 2, 32'h100);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
    set_solver(31, 0, 32'hffffffff);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
    set_solver(16, 1, 0);
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_solver(4, 2, 0);
    hold_req = 1;
    send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_word(sds_pkg::REQ_RHS, i, 0, rand_value());
    wait_drained();
  endtask

  task automatic test_random_solves();
    int sent;
    int n;
    int loads;
    int unsigned tol;
    sent = 0;
    while (sent < 50) begin
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(17, 31);
        write_reg(sds_pkg::CFG_SIZE, n);
        write_reg(sds_pkg::CFG_MAX_ITER, $urandom_range(0, 2));
        n = 16;
      end else begin
        n = $urandom_range(0, 4);
        write_reg(sds_pkg::CFG_SIZE, n);
        write_reg(sds_pkg::CFG_MAX_ITER, $urandom_range(0, 8));
        if (n == 0) n = 1;
      end
      case ($urandom_range(0, 3))
        0:       tol = 0;
        1:       tol = $urandom();
        2:       tol = 32'hffffffff;
        default: tol = $urandom_range(0, 32'h10000);
      endcase
      write_reg(sds_pkg::CFG_TOLERANCE, tol);
      loads = $urandom_range(0, 8);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(sds_pkg::req_t'($urandom_range(0, 2)), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom());
        end else begin
          case ($urandom_range(0, 2))
            0: send_word(sds_pkg::REQ_MATRIX, $urandom_range(0, n - 1),
                         $urandom_range(0, n - 1), rand_value());
            1: send_word(sds_pkg::REQ_RHS, $urandom_range(0, n - 1), $urandom_range(0, 15),
                         rand_value());
            default: send_word(sds_pkg::REQ_START, $urandom_range(0, n - 1),
                               $urandom_range(0, 15), rand_value());
          endcase
        end
      end
      send_word(sds_pkg::REQ_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
      if ($urandom_range(0, 3) == 0) begin
        send_word(sds_pkg::REQ_SOLVE, 0, 0, 0);
        sent++;
      end
      sent += loads + 1;
      wait_drained();
    end
    send_burst = 0;
    recv_burst = 0;
  endtask

  initial begin
    failed      = 0;
    send_burst  = 0;
    recv_burst  = 0;
    hold_req    = 0;
    idle_cycles = 0;
    size_reg    = 16;
    iter_reg    = 100;
    tol_reg     = 1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sds_pkg::CFG_SIZE;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_special_cases();
    test_output_backpressure();
    test_random_solves();
    wait_drained();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
